/* rtl/tmt_pkg.sv */
// Types, constants and stage functions for the TinyMT32 state initializer.
`default_nettype none

package tmt_pkg;

    typedef logic [31:0]       t_word;
    typedef logic [3:0][31:0]  t_state;

    localparam t_word MixMult    = 32'd1812433253;
    localparam t_word Low31Mask  = 32'h7fff_ffff;
    localparam t_word MaskOneRst = 32'hF20D_1B78;
    localparam t_word MaskTwoRst = 32'hFF90_FFE5;
    localparam t_word TmatRst    = 32'h30FB_DFFF;

    localparam int MixRounds  = 7;
    localparam int AdvStages  = 4;   // two next-state steps per stage
    localparam int NumStages  = MixRounds + AdvStages;
    localparam int ShiftA     = 1;
    localparam int ShiftB     = 10;

    typedef enum logic [1:0] {
        CFG_MASK_ONE    = 2'd0,
        CFG_MASK_TWO    = 2'd1,
        CFG_TEMPER_MASK = 2'd2,
        CFG_UNUSED      = 2'd3
    } t_cfg_idx;

    // One mixing round: rnd runs 1..7.
    function automatic t_state mix_round(t_state s, logic [2:0] rnd);
        logic [1:0] dst;
        logic [1:0] src;
        t_word      p;
        t_word      prod;
        t_state     r;
        dst  = rnd[1:0];
        src  = rnd[1:0] - 2'd1;
        p    = s[src];
        prod = MixMult * (p ^ (p >> 30));
        r    = s;
        r[dst] = s[dst] ^ ({29'd0, rnd} + prod);
        return r;
    endfunction

    // One TinyMT next-state step.
    function automatic t_state advance(t_state s, t_word m1, t_word m2);
        t_word  x;
        t_word  y;
        t_word  sel;
        t_state r;
        x   = (s[0] & Low31Mask) ^ s[1] ^ s[2];
        x   = x ^ (x << ShiftA);
        y   = s[3] ^ (s[3] >> ShiftA) ^ x;
        sel = {32{y[0]}};
        r[0] = s[1];
        r[1] = s[2] ^ (sel & m1);
        r[2] = x ^ (y << ShiftB) ^ (sel & m2);
        r[3] = y;
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/tinymt32_state_init.sv */
// Top level: pipelined TinyMT32 initial-state generator.
`default_nettype none

// Takes one 32-bit seed per transfer and returns the four-word TinyMT32 state
// built from it, with the batch flag copied through. The datapath is an
// 11-stage pipeline: seven stages each hold one mixing round (one 32x32
// multiplier, low half kept), then four stages each run two next-state steps.
// A result is registered through every stage in order and is offered from the
// last stage; one seed is taken every clock when the output side
// keeps up, and empty stages close up while the output stalls. The mask
// registers are read live by the stages, so write them only when the pipeline
// is empty.
module tinymt32_state_init (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    // seed channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [31:0] i_seed,
    input  wire logic        i_last_in_batch,
    // state channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_word_zero,
    output logic [31:0]      o_word_one,
    output logic [31:0]      o_word_two,
    output logic [31:0]      o_word_three,
    output logic             o_batch_done
);

    localparam int N = tmt_pkg::NumStages;

    tmt_pkg::t_word r_mask_one;
    tmt_pkg::t_word r_mask_two;
    tmt_pkg::t_word r_temper_mask;

    logic            [N-1:0] r_vld;
    logic            [N-1:0] r_last;
    tmt_pkg::t_state         r_data [N];
    tmt_pkg::t_state         n_data [N];
    logic            [N:0]   rdy;
    logic            [N-1:0] vld_in;
    logic            [N-1:0] last_in;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_one    <= tmt_pkg::MaskOneRst;
            r_mask_two    <= tmt_pkg::MaskTwoRst;
            r_temper_mask <= tmt_pkg::TmatRst;
        end else if (i_cfg_we) begin
            unique case (tmt_pkg::t_cfg_idx'(i_cfg_idx))
                tmt_pkg::CFG_MASK_ONE:    r_mask_one    <= i_cfg_data;
                tmt_pkg::CFG_MASK_TWO:    r_mask_two    <= i_cfg_data;
                tmt_pkg::CFG_TEMPER_MASK: r_temper_mask <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // a stage may load when it is empty or its contents move on
    always_comb begin
        rdy[N] = i_out_ready;
        for (int k = N - 1; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    always_comb begin
        vld_in[0]  = i_in_valid;
        last_in[0] = i_last_in_batch;
        for (int k = 1; k < N; k++) begin
            vld_in[k]  = r_vld[k-1];
            last_in[k] = r_last[k-1];
        end
    end

    always_comb begin
        n_data[0] = tmt_pkg::mix_round(
            {r_temper_mask, r_mask_two, r_mask_one, i_seed}, 3'd1);
        for (int k = 1; k < tmt_pkg::MixRounds; k++) begin
            n_data[k] = tmt_pkg::mix_round(r_data[k-1], 3'(k + 1));
        end
        for (int k = tmt_pkg::MixRounds; k < N; k++) begin
            n_data[k] = tmt_pkg::advance(
                tmt_pkg::advance(r_data[k-1], r_mask_one, r_mask_two),
                r_mask_one, r_mask_two);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < N; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= vld_in[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < N; k++) begin
            if (rdy[k] && vld_in[k]) begin
                r_data[k] <= n_data[k];
                r_last[k] <= last_in[k];
            end
        end
    end

    assign o_in_ready   = rdy[0];
    assign o_out_valid  = r_vld[N-1];
    assign o_word_zero  = r_data[N-1][0];
    assign o_word_one   = r_data[N-1][1];
    assign o_word_two   = r_data[N-1][2];
    assign o_word_three = r_data[N-1][3];
    assign o_batch_done = r_last[N-1];

    // input stalls only when every stage is occupied
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (&r_vld))
        else $error("input stalled with a bubble in the pipeline");

    // occupancy grows by one on an input transfer without an output transfer
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !(o_out_valid && i_out_ready)) |=>
        ($countones(r_vld) == $past($countones(r_vld)) + 1))
        else $error("pipeline lost or duplicated an item on input");

    // occupancy drops by one on an output transfer without an input transfer
    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !(i_in_valid && o_in_ready)) |=>
        ($countones(r_vld) + 1 == $past($countones(r_vld))))
        else $error("pipeline lost or duplicated an item on output");

endmodule

`default_nettype wire

/* verif/tb_tinymt32_state_init.sv */
// Testbench for tinymt32_state_init: seeds in, predicted TinyMT32 initial states checked out.
`timescale 1ns / 1ps

module tb_tinymt32_state_init;

    localparam int WatchdogLimit = 2000;
    localparam int NumPhases     = 8;
    localparam int SeedsPerPhase = 131;

    typedef struct packed {
        tmt_pkg::t_word word_zero;
        tmt_pkg::t_word word_one;
        tmt_pkg::t_word word_two;
        tmt_pkg::t_word word_three;
        logic           batch_done;
    } t_init_state;

    // Keeps its own copy of the mask registers and predicts each state.
    class t_state_board;
        tmt_pkg::t_word mask_one;
        tmt_pkg::t_word mask_two;
        tmt_pkg::t_word temper_mask;
        t_init_state    expected_states[$];
        int             mismatches;

        function new();
            mask_one    = tmt_pkg::MaskOneRst;
            mask_two    = tmt_pkg::MaskTwoRst;
            temper_mask = tmt_pkg::TmatRst;
            mismatches  = 0;
        endfunction

        function void set_reg(tmt_pkg::t_cfg_idx idx, tmt_pkg::t_word data);
            case (idx)
                tmt_pkg::CFG_MASK_ONE:    mask_one = data;
                tmt_pkg::CFG_MASK_TWO:    mask_two = data;
                tmt_pkg::CFG_TEMPER_MASK: temper_mask = data;
                default: ;  // unused index, write is dropped
            endcase
        endfunction

        function void note_seed(tmt_pkg::t_word seed, logic last);
            tmt_pkg::t_word w[4];
            tmt_pkg::t_word p;
            tmt_pkg::t_word x;
            tmt_pkg::t_word y;
            t_init_state    st;
            w[0] = seed;
            w[1] = mask_one;
            w[2] = mask_two;
            w[3] = temper_mask;
            for (int k = 1; k < 8; k++) begin
                p = w[(k - 1) & 3];
                w[k & 3] = w[k & 3] ^ (tmt_pkg::t_word'(k) +
                    tmt_pkg::t_word'(tmt_pkg::MixMult * (p ^ (p >> 30))));
            end
            for (int k = 0; k < 8; k++) begin
                x = (w[0] & 32'h7fff_ffff) ^ w[1] ^ w[2];
                x = x ^ (x << 1);
                y = w[3] ^ (w[3] >> 1) ^ x;
                w[0] = w[1];
                w[1] = w[2] ^ (y[0] ? mask_one : 32'd0);
                w[2] = x ^ (y << 10) ^ (y[0] ? mask_two : 32'd0);
                w[3] = y;
            end
            st.word_zero  = w[0];
            st.word_one   = w[1];
            st.word_two   = w[2];
            st.word_three = w[3];
            st.batch_done = last;
            expected_states.push_back(st);
        endfunction

        function void check_state(tmt_pkg::t_word w0, tmt_pkg::t_word w1,
                                  tmt_pkg::t_word w2, tmt_pkg::t_word w3, logic done);
            t_init_state exp_st;
            if (expected_states.size() == 0) begin
                $error("state transfer with nothing expected: %h %h %h %h %b",
                       w0, w1, w2, w3, done);
                mismatches++;
                return;
            end
            exp_st = expected_states.pop_front();
            if (w0 !== exp_st.word_zero) begin
                $error("word_zero: expected %h, actual %h", exp_st.word_zero, w0);
                mismatches++;
            end
            if (w1 !== exp_st.word_one) begin
                $error("word_one: expected %h, actual %h", exp_st.word_one, w1);
                mismatches++;
            end
            if (w2 !== exp_st.word_two) begin
                $error("word_two: expected %h, actual %h", exp_st.word_two, w2);
                mismatches++;
            end
            if (w3 !== exp_st.word_three) begin
                $error("word_three: expected %h, actual %h", exp_st.word_three, w3);
                mismatches++;
            end
            if (done !== exp_st.batch_done) begin
                $error("batch_done: expected %b, actual %b", exp_st.batch_done, done);
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_we        = 1'b0;
    logic [1:0]  i_cfg_idx       = tmt_pkg::CFG_MASK_ONE;
    logic [31:0] i_cfg_data      = 32'd0;
    logic        i_in_valid      = 1'b0;
    logic        o_in_ready;
    logic [31:0] i_seed          = 32'd0;
    logic        i_last_in_batch = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready     = 1'b0;
    logic [31:0] o_word_zero;
    logic [31:0] o_word_one;
    logic [31:0] o_word_two;
    logic [31:0] o_word_three;
    logic        o_batch_done;

    t_state_board board;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int hold_request       = 0;
    int hold_left          = 0;

    tinymt32_state_init dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_seed          (i_seed),
        .i_last_in_batch (i_last_in_batch),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_word_zero     (o_word_zero),
        .o_word_one      (o_word_one),
        .o_word_two      (o_word_two),
        .o_word_three    (o_word_three),
        .o_batch_done    (o_batch_done)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Receiver: random stalls, plus a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            board.check_state(o_word_zero, o_word_one, o_word_two, o_word_three, o_batch_done);
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WatchdogLimit) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tinymt32_state_init regression: fail");
        $finish;
    end

    task automatic set_idling(input int mode);
        case (mode)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 83; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 83; end
            default: begin sender_idle_pct = 19; receiver_stall_pct = 19; end
        endcase
    endtask

    // Called at a rising edge; returns at the edge where the transfer happens.
    task automatic send_seed(input tmt_pkg::t_word seed, input logic last);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_seed          <= seed;
        i_last_in_batch <= last;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_seed(seed, last);
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (board.expected_states.size() != 0);
    endtask

    task automatic write_reg(input tmt_pkg::t_cfg_idx idx, input tmt_pkg::t_word data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.set_reg(idx, data);
        @(posedge i_clk);
    endtask

    task automatic load_masks(input tmt_pkg::t_word m1, input tmt_pkg::t_word m2,
                              input tmt_pkg::t_word tm);
        write_reg(tmt_pkg::CFG_MASK_ONE, m1);
        write_reg(tmt_pkg::CFG_MASK_TWO, m2);
        write_reg(tmt_pkg::CFG_TEMPER_MASK, tm);
    endtask

    function automatic tmt_pkg::t_word pick_seed();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'hffff_ffff;
            2: return 32'd1 << $urandom_range(0, 31);
            3: return ~(32'd1 << $urandom_range(0, 31));
            4: return tmt_pkg::t_word'($urandom_range(0, 255));
            default: return $urandom;
        endcase
    endfunction

    initial begin
        board = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: seed extremes under reset masks
        set_idling(0);
        send_seed(32'h0000_0000, 1'b0);
        send_seed(32'hffff_ffff, 1'b1);
        send_seed(32'h0000_0001, 1'b0);
        send_seed(32'h8000_0000, 1'b0);
        send_seed(32'h7fff_ffff, 1'b1);
        send_seed(32'haaaa_aaaa, 1'b0);
        send_seed(32'h5555_5555, 1'b1);
        send_seed(32'h1234_5678, 1'b0);
        wait_drain();
        // write to the unused index must leave the masks alone
        write_reg(tmt_pkg::CFG_UNUSED, $urandom);
        send_seed(32'h0000_0000, 1'b1);
        send_seed(32'hffff_ffff, 1'b0);
        wait_drain();
        // zero masks and zero seed: closest to an all-zero state
        load_masks(32'd0, 32'd0, 32'd0);
        send_seed(32'h0000_0000, 1'b1);
        send_seed(32'hffff_ffff, 1'b0);
        wait_drain();
        load_masks(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_seed(32'h0000_0000, 1'b0);
        send_seed(32'hffff_ffff, 1'b1);
        wait_drain();
        load_masks(tmt_pkg::MaskOneRst, tmt_pkg::MaskTwoRst, tmt_pkg::TmatRst);

        for (int ph = 0; ph < NumPhases; ph++) begin
            set_idling(ph % 4);
            case (ph)
                1: load_masks(32'd0, 32'd0, 32'd0);
                2: load_masks(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
                4: load_masks(tmt_pkg::MaskOneRst, tmt_pkg::MaskTwoRst, tmt_pkg::TmatRst);
                6: load_masks(32'hffff_ffff, 32'd0, $urandom);
                3, 5, 7: load_masks($urandom, $urandom, $urandom);
                default: ;
            endcase
            // long receiver hold-off while seeds keep coming: pipeline fills up
            if (ph == 4)
                hold_request = 120;
            for (int n = 0; n < SeedsPerPhase; n++) begin
                if (ph == 5 && n == SeedsPerPhase / 2)
                    wait_drain();
                send_seed(pick_seed(), $urandom_range(0, 7) == 0);
            end
            wait_drain();
        end

        repeat (24) @(posedge i_clk);
        if (board.mismatches == 0 && board.expected_states.size() == 0)
            $display("tinymt32_state_init regression: pass");
        else
            $display("tinymt32_state_init regression: fail");
        $finish;
    end

endmodule

/* sim.f */
rtl/tmt_pkg.sv
rtl/tinymt32_state_init.sv
verif/tb_tinymt32_state_init.sv
